// ----- hdl/spk_pkg.sv -----
// Shared types and constants for the SPECK 128/128 block cipher engine.
// No dependencies; imported by spk_round and speck_block_cipher.
`timescale 1ns / 1ps

package spk_pkg;

    localparam int WORD_W   = 64;
    localparam int BLOCK_W  = 2 * WORD_W;
    localparam int ROUNDS   = 32;
    localparam int RND_W    = $clog2(ROUNDS);
    localparam int ROT_X    = 8;
    localparam int ROT_Y    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

// ----- hdl/spk_round.sv -----
// One SPECK 128/128 round, forward and inverse, on a shared set of inputs.
// Depends on spk_pkg for word width and rotation amounts.
`timescale 1ns / 1ps

module spk_round (
    input  spk_pkg::t_word i_x,
    input  spk_pkg::t_word i_y,
    input  spk_pkg::t_word i_k,
    output spk_pkg::t_word o_fwd_x,
    output spk_pkg::t_word o_fwd_y,
    output spk_pkg::t_word o_inv_x,
    output spk_pkg::t_word o_inv_y
);
    import spk_pkg::*;

    t_word fx;
    t_word iy;
    t_word ix;

    // forward: x = (ror(x,8) + y) ^ k ; y = rol(y,3) ^ x
    assign fx      = ({i_x[ROT_X-1:0], i_x[WORD_W-1:ROT_X]} + i_y) ^ i_k;
    assign o_fwd_x = fx;
    assign o_fwd_y = {i_y[WORD_W-ROT_Y-1:0], i_y[WORD_W-1:WORD_W-ROT_Y]} ^ fx;

    // inverse: y = ror(y ^ x, 3) ; x = rol((x ^ k) - y, 8)
    always_comb begin
        t_word t;
        t  = i_y ^ i_x;
        iy = {t[ROT_Y-1:0], t[WORD_W-1:ROT_Y]};
        ix = (i_x ^ i_k) - iy;
    end

    assign o_inv_y = iy;
    assign o_inv_x = {ix[WORD_W-ROT_X-1:0], ix[WORD_W-1:WORD_W-ROT_X]};

endmodule

// ----- hdl/speck_block_cipher.sv -----
// SPECK 128/128 block cipher engine, top level.
// A block accepted in ST_IDLE runs all rounds on a ready key schedule; after a key write the
// first block waits for the schedule expansion and one read setup. Blocks do not overlap, as
// set by the single shared round unit and the one read port of the round-key memory. Reset
// (i_rst_n low, synchronous) clears keys, mode, the schedule flag and the output beat; the
// round-key memory itself is not cleared.
`timescale 1ns / 1ps

module speck_block_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  spk_pkg::t_word                i_cfg_data,
    // input block stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spk_pkg::BLOCK_W-1:0]   s_axis_tdata,  // [63:0] block_low, [127:64] block_high
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spk_pkg::BLOCK_W-1:0]   m_axis_tdata   // [63:0] result_low, [127:64] result_high
);
    import spk_pkg::*;

    // control and configuration registers
    t_state            r_state,        n_state;
    logic [RND_W-1:0]  r_cnt,          n_cnt;
    logic              r_sched_ready,  n_sched_ready;
    logic              r_mode,         n_mode;
    t_word             r_key_low,      n_key_low;
    t_word             r_key_high,     n_key_high;
    logic              r_out_valid,    n_out_valid;

    // datapath registers
    t_word             r_x,  n_x;
    t_word             r_y,  n_y;
    t_word             r_ka, n_ka;
    t_word             r_kb, n_kb;
    logic [BLOCK_W-1:0] r_out_data, n_out_data;

    // round-key memory: one write port, one registered read port
    t_word             r_round_keys [ROUNDS];
    t_word             r_rk_rd;
    logic              mem_we;
    logic [RND_W-1:0]  mem_waddr;
    t_word             mem_wdata;
    logic [RND_W-1:0]  mem_raddr;

    // shared round unit
    t_word rnd_x, rnd_y, rnd_k;
    t_word fwd_x, fwd_y, inv_x, inv_y;
    t_word res_x, res_y;

    logic              out_free;
    logic [RND_W-1:0]  cnt_next;

    spk_round u_round (
        .i_x     (rnd_x),
        .i_y     (rnd_y),
        .i_k     (rnd_k),
        .o_fwd_x (fwd_x),
        .o_fwd_y (fwd_y),
        .o_inv_x (inv_x),
        .o_inv_y (inv_y)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || m_axis_tready;
    assign cnt_next = r_cnt + 1'b1;

    // During expansion the unit runs on the key words with the round number as key;
    // otherwise it runs on the block with the key just read from memory.
    always_comb begin
        if (r_state == ST_EXPAND) begin
            rnd_x = r_kb;
            rnd_y = r_ka;
            rnd_k = WORD_W'(r_cnt);
        end else begin
            rnd_x = r_x;
            rnd_y = r_y;
            rnd_k = r_rk_rd;
        end
        res_x = r_mode ? inv_x : fwd_x;
        res_y = r_mode ? inv_y : fwd_y;
    end

    // Read address: in a round, fetch the key for the following round; elsewhere keep
    // the first key of the current mode on the read port so a round can start at once.
    // Decryption walks the keys from the top down.
    always_comb begin
        if (r_state == ST_RUN) begin
            mem_raddr = r_mode ? (LAST_RND - cnt_next) : cnt_next;
        end else begin
            mem_raddr = r_mode ? LAST_RND : '0;
        end
    end

    // next state and datapath
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_sched_ready = r_sched_ready;
        n_mode        = r_mode;
        n_key_low     = r_key_low;
        n_key_high    = r_key_high;
        n_out_valid   = r_out_valid;
        n_x           = r_x;
        n_y           = r_y;
        n_ka          = r_ka;
        n_kb          = r_kb;
        n_out_data    = r_out_data;
        mem_we        = 1'b0;
        mem_waddr     = r_cnt;
        mem_wdata     = r_ka;

        // drop the result beat once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_y   = s_axis_tdata[WORD_W-1:0];
                    n_x   = s_axis_tdata[BLOCK_W-1:WORD_W];
                    n_cnt = '0;
                    if (r_sched_ready) begin
                        n_state = ST_RUN;
                    end else begin
                        // schedule stale: expand from the key registers first
                        n_ka    = r_key_low;
                        n_kb    = r_key_high;
                        n_state = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND: begin
                // store word a as round key, then advance the schedule one round
                mem_we = 1'b1;
                n_kb   = fwd_x;
                n_ka   = fwd_y;
                n_cnt  = cnt_next;
                if (r_cnt == LAST_RND) begin
                    n_sched_ready = 1'b1;
                    n_cnt         = '0;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                // wait state for the first key read after the last write has landed
                n_state = ST_RUN;
            end
            ST_RUN: begin
                n_x   = res_x;
                n_y   = res_y;
                n_cnt = cnt_next;
                if (r_cnt == LAST_RND) begin
                    n_cnt = '0;
                    if (out_free) begin
                        n_out_data  = {res_x, res_y};
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        // hold the finished block until the output beat drains
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_data  = {r_x, r_y};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // user keeps configuration writes to idle (not enforced); key writes stale the schedule
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_LOW: begin
                    n_key_low     = i_cfg_data;
                    n_sched_ready = 1'b0;
                end
                REG_KEY_HIGH: begin
                    n_key_high    = i_cfg_data;
                    n_sched_ready = 1'b0;
                end
                REG_DECRYPT: begin
                    n_mode = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_sched_ready <= 1'b0;
            r_mode        <= 1'b0;
            r_key_low     <= '0;
            r_key_high    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_sched_ready <= n_sched_ready;
            r_mode        <= n_mode;
            r_key_low     <= n_key_low;
            r_key_high    <= n_key_high;
            r_out_valid   <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_ka       <= n_ka;
        r_kb       <= n_kb;
        r_out_data <= n_out_data;
    end

    // round-key memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_round_keys[mem_waddr] <= mem_wdata;
        end
        r_rk_rd <= r_round_keys[mem_raddr];
    end

endmodule
